/* sv/jbt_pkg.sv */
// Shared types, codes and character tables for the JSON byte tokenizer.
package jbt_pkg;

    // Lexer mode; codes above MODE_LIT never occur and behave as idle
    typedef enum logic [2:0] {
        MODE_IDLE = 3'd0,
        MODE_STR  = 3'd1,
        MODE_ESC  = 3'd2,
        MODE_NUM  = 3'd3,
        MODE_LIT  = 3'd4
    } t_mode;

    // Event kinds on the output stream
    localparam logic [3:0] KIND_STRING   = 4'd0;
    localparam logic [3:0] KIND_NUMBER   = 4'd1;
    localparam logic [3:0] KIND_LBRACE   = 4'd2;
    localparam logic [3:0] KIND_RBRACE   = 4'd3;
    localparam logic [3:0] KIND_LBRACKET = 4'd4;
    localparam logic [3:0] KIND_RBRACKET = 4'd5;
    localparam logic [3:0] KIND_COLON    = 4'd6;
    localparam logic [3:0] KIND_COMMA    = 4'd7;
    localparam logic [3:0] KIND_TRUE     = 4'd8;
    localparam logic [3:0] KIND_END      = 4'd11;
    localparam logic [3:0] KIND_PAYLOAD  = 4'd12;

    // Literal words
    localparam logic [1:0] WORD_TRUE  = 2'd0;
    localparam logic [1:0] WORD_FALSE = 2'd1;
    localparam logic [1:0] WORD_NULL  = 2'd2;

    // Characters the lexer looks for
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_UPPER_E = 8'h45;
    localparam logic [7:0] CH_LBRACK  = 8'h5B;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_RBRACK  = 8'h5D;
    localparam logic [7:0] CH_LOWER_E = 8'h65;
    localparam logic [7:0] CH_LOWER_F = 8'h66;
    localparam logic [7:0] CH_LOWER_N = 8'h6E;
    localparam logic [7:0] CH_LOWER_T = 8'h74;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;

    // Queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // One item's worth of events: unk unknowns first, then n_ev listed events
    typedef struct packed {
        logic [2:0]      unk;
        logic [1:0]      n_ev;
        logic [2:0][3:0] kind;
        logic [2:0][7:0] pay;
    } t_cmd;

    // Letter m of literal word w
    function automatic logic [7:0] lit_char(input logic [1:0] w, input logic [2:0] m);
        logic [7:0] c;
        c = 8'h00;
        case ({w, m})
            {WORD_TRUE,  3'd0}: c = 8'h74;  // t
            {WORD_TRUE,  3'd1}: c = 8'h72;  // r
            {WORD_TRUE,  3'd2}: c = 8'h75;  // u
            {WORD_TRUE,  3'd3}: c = 8'h65;  // e
            {WORD_FALSE, 3'd0}: c = 8'h66;  // f
            {WORD_FALSE, 3'd1}: c = 8'h61;  // a
            {WORD_FALSE, 3'd2}: c = 8'h6C;  // l
            {WORD_FALSE, 3'd3}: c = 8'h73;  // s
            {WORD_FALSE, 3'd4}: c = 8'h65;  // e
            {WORD_NULL,  3'd0}: c = 8'h6E;  // n
            {WORD_NULL,  3'd1}: c = 8'h75;  // u
            {WORD_NULL,  3'd2}: c = 8'h6C;  // l
            {WORD_NULL,  3'd3}: c = 8'h6C;  // l
            default:            c = 8'h00;
        endcase
        return c;
    endfunction

    // Length of literal word w
    function automatic logic [2:0] lit_len(input logic [1:0] w);
        logic [2:0] n;
        case (w)
            WORD_FALSE: n = 3'd5;
            default:    n = 3'd4;
        endcase
        return n;
    endfunction

endpackage

/* sv/jbt_front.sv */
// Front end: lexer state and per-byte classification into one event group.
module jbt_front import jbt_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_byte,
    input  logic       i_end,
    input  logic       i_full,
    output logic       o_push,
    output t_cmd       o_cmd
);

    t_mode      r_mode, n_mode;
    logic [1:0] r_word, n_word;
    logic [2:0] r_matched, n_matched;
    logic [1:0] r_num_len, n_num_len;
    logic       r_prev_exp, n_prev_exp;

    // Idle-mode view of the byte
    logic       id_has;
    logic [3:0] id_kind;
    logic [7:0] id_pay;
    t_mode      id_mode;
    logic [1:0] id_word;
    logic       is_digit;

    // Working values
    t_cmd       cmd;
    logic       use_idle;
    logic [1:0] idle_slot;
    logic       is_sign;
    logic       is_exp;
    logic       take;
    logic       lit_hit;
    logic       lit_done;
    logic [1:0] w_eff;
    logic [2:0] m_next;
    logic [2:0] total;
    logic       accept;

    assign accept  = i_valid && !i_full;
    assign o_ready = !i_full;

    assign is_digit = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
    assign is_sign  = (i_byte == CH_PLUS) || (i_byte == CH_MINUS);
    assign is_exp   = (i_byte == CH_LOWER_E) || (i_byte == CH_UPPER_E);

    // Number goes on; a sign only as the second character or right after e/E
    assign take = is_sign ? ((r_num_len < 2'd2) || r_prev_exp)
                          : (is_digit || (i_byte == CH_DOT) || is_exp);

    // Literal matching against the word in progress
    assign w_eff    = (r_word == WORD_TRUE || r_word == WORD_FALSE || r_word == WORD_NULL)
                      ? r_word : WORD_TRUE;
    assign m_next   = r_matched + 3'd1;
    assign lit_hit  = (r_matched < lit_len(w_eff))
                      && (i_byte == lit_char(w_eff, r_matched));
    assign lit_done = (m_next == lit_len(w_eff));

    // How a byte is lexed between tokens
    always_comb begin
        id_has  = 1'b1;
        id_kind = KIND_END;
        id_pay  = 8'h00;
        id_mode = MODE_IDLE;
        id_word = WORD_TRUE;
        if (((i_byte >= CH_TAB) && (i_byte <= CH_CR)) || (i_byte == CH_SPACE)) begin
            id_has = 1'b0;
        end else if (i_byte == CH_LBRACE) begin
            id_kind = KIND_LBRACE;
        end else if (i_byte == CH_RBRACE) begin
            id_kind = KIND_RBRACE;
        end else if (i_byte == CH_LBRACK) begin
            id_kind = KIND_LBRACKET;
        end else if (i_byte == CH_RBRACK) begin
            id_kind = KIND_RBRACKET;
        end else if (i_byte == CH_COLON) begin
            id_kind = KIND_COLON;
        end else if (i_byte == CH_COMMA) begin
            id_kind = KIND_COMMA;
        end else if (i_byte == CH_QUOTE) begin
            id_has  = 1'b0;
            id_mode = MODE_STR;
        end else if (i_byte == CH_LOWER_T) begin
            id_has  = 1'b0;
            id_mode = MODE_LIT;
            id_word = WORD_TRUE;
        end else if (i_byte == CH_LOWER_F) begin
            id_has  = 1'b0;
            id_mode = MODE_LIT;
            id_word = WORD_FALSE;
        end else if (i_byte == CH_LOWER_N) begin
            id_has  = 1'b0;
            id_mode = MODE_LIT;
            id_word = WORD_NULL;
        end else if ((i_byte == CH_MINUS) || is_digit) begin
            id_kind = KIND_PAYLOAD;
            id_pay  = i_byte;
            id_mode = MODE_NUM;
        end
    end

    // Whether the byte is lexed again from idle, and at which event slot
    always_comb begin
        use_idle  = 1'b0;
        idle_slot = 2'd0;
        if (!i_end) begin
            case (r_mode)
                MODE_STR: use_idle = 1'b0;
                MODE_ESC: use_idle = 1'b0;
                MODE_NUM: begin
                    // number closes first, so the relexed event comes second
                    use_idle  = !take;
                    idle_slot = 2'd1;
                end
                MODE_LIT: use_idle = !lit_hit;
                default:  use_idle = 1'b1;
            endcase
        end
    end

    // Next lexer state
    always_comb begin
        n_mode     = r_mode;
        n_word     = r_word;
        n_matched  = r_matched;
        n_num_len  = r_num_len;
        n_prev_exp = r_prev_exp;
        if (i_end) begin
            n_mode     = MODE_IDLE;
            n_word     = WORD_TRUE;
            n_matched  = 3'd0;
            n_num_len  = 2'd0;
            n_prev_exp = 1'b0;
        end else if (use_idle) begin
            n_mode     = id_mode;
            n_word     = id_word;
            n_matched  = (id_mode == MODE_LIT) ? 3'd1 : 3'd0;
            n_num_len  = (id_mode == MODE_NUM) ? 2'd1 : 2'd0;
            n_prev_exp = 1'b0;
        end else begin
            case (r_mode)
                MODE_STR: begin
                    if (i_byte == CH_QUOTE) begin
                        n_mode = MODE_IDLE;
                    end else if (i_byte == CH_BSLASH) begin
                        n_mode = MODE_ESC;
                    end
                end
                MODE_ESC: begin
                    n_mode = MODE_STR;
                end
                MODE_NUM: begin
                    if (r_num_len < 2'd2) begin
                        n_num_len = r_num_len + 2'd1;
                    end
                    n_prev_exp = is_exp;
                end
                MODE_LIT: begin
                    if (lit_done) begin
                        n_mode     = MODE_IDLE;
                        n_word     = WORD_TRUE;
                        n_matched  = 3'd0;
                        n_num_len  = 2'd0;
                        n_prev_exp = 1'b0;
                    end else begin
                        n_matched = m_next;
                    end
                end
                default: begin
                    n_mode = r_mode;
                end
            endcase
        end
    end

    // Event group of the byte
    always_comb begin
        cmd = '0;
        if (i_end) begin
            // close whatever is open, then one end event
            case (r_mode)
                MODE_ESC: begin
                    cmd.kind[0] = KIND_PAYLOAD;
                    cmd.pay[0]  = CH_BSLASH;
                    cmd.kind[1] = KIND_STRING;
                    cmd.kind[2] = KIND_END;
                    cmd.n_ev    = 2'd3;
                end
                MODE_STR: begin
                    cmd.kind[0] = KIND_STRING;
                    cmd.kind[1] = KIND_END;
                    cmd.n_ev    = 2'd2;
                end
                MODE_NUM: begin
                    cmd.kind[0] = KIND_NUMBER;
                    cmd.kind[1] = KIND_END;
                    cmd.n_ev    = 2'd2;
                end
                MODE_LIT: begin
                    cmd.unk     = r_matched;
                    cmd.kind[0] = KIND_END;
                    cmd.n_ev    = 2'd1;
                end
                default: begin
                    cmd.kind[0] = KIND_END;
                    cmd.n_ev    = 2'd1;
                end
            endcase
        end else begin
            case (r_mode)
                MODE_STR: begin
                    if (i_byte == CH_QUOTE) begin
                        cmd.kind[0] = KIND_STRING;
                        cmd.n_ev    = 2'd1;
                    end else if (i_byte != CH_BSLASH) begin
                        cmd.kind[0] = KIND_PAYLOAD;
                        cmd.pay[0]  = i_byte;
                        cmd.n_ev    = 2'd1;
                    end
                end
                MODE_ESC: begin
                    cmd.kind[0] = KIND_PAYLOAD;
                    cmd.n_ev    = 2'd1;
                    if (i_byte == CH_LOWER_N) begin
                        cmd.pay[0] = CH_LF;
                    end else if (i_byte == CH_LOWER_T) begin
                        cmd.pay[0] = CH_TAB;
                    end else begin
                        cmd.pay[0] = i_byte;
                    end
                end
                MODE_NUM: begin
                    if (take) begin
                        cmd.kind[0] = KIND_PAYLOAD;
                        cmd.pay[0]  = i_byte;
                        cmd.n_ev    = 2'd1;
                    end else begin
                        cmd.kind[0] = KIND_NUMBER;
                    end
                end
                MODE_LIT: begin
                    if (lit_hit) begin
                        if (lit_done) begin
                            cmd.kind[0] = KIND_TRUE + {2'b00, w_eff};
                            cmd.n_ev    = 2'd1;
                        end
                    end else begin
                        // one unknown per matched letter, then relex
                        cmd.unk = r_matched;
                    end
                end
                default: begin
                    cmd.unk = 3'd0;
                end
            endcase

            if (use_idle) begin
                if (id_has) begin
                    cmd.kind[idle_slot] = id_kind;
                    cmd.pay[idle_slot]  = id_pay;
                    cmd.n_ev            = idle_slot + 2'd1;
                end else begin
                    cmd.n_ev = idle_slot;
                end
            end
        end
    end

    assign total  = cmd.unk + {1'b0, cmd.n_ev};
    assign o_cmd  = cmd;
    assign o_push = accept && (total != 3'd0);

    // Lexer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_IDLE;
            r_word     <= WORD_TRUE;
            r_matched  <= 3'd0;
            r_num_len  <= 2'd0;
            r_prev_exp <= 1'b0;
        end else if (accept) begin
            r_mode     <= n_mode;
            r_word     <= n_word;
            r_matched  <= n_matched;
            r_num_len  <= n_num_len;
            r_prev_exp <= n_prev_exp;
        end
    end

endmodule

/* sv/jbt_queue.sv */
// Short queue of event groups between front end and back end.
module jbt_queue import jbt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_empty,
    output logic o_full
);

    t_cmd              r_slot [Q_DEPTH];
    logic [Q_AW-1:0]   r_wr_ptr;
    logic [Q_AW-1:0]   r_rd_ptr;
    logic [Q_AW:0]     r_count;
    logic              do_push;
    logic              do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == (Q_AW+1)'(Q_DEPTH));
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_slot[r_rd_ptr];

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* sv/jbt_back.sv */
// Back end: expands one event group into single events on a registered output.
module jbt_back import jbt_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_empty,
    input  t_cmd       i_cmd,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [3:0] o_kind,
    output logic [7:0] o_pay,
    output logic       o_last
);

    logic [2:0] r_pos;
    logic       r_valid;
    logic [3:0] r_kind;
    logic [7:0] r_pay;
    logic       r_last;

    logic       load;
    logic [2:0] total;
    logic [2:0] idx;
    logic [3:0] ev_kind;
    logic [7:0] ev_pay;
    logic       ev_last;

    assign load  = !r_valid || i_ready;
    assign total = i_cmd.unk + {1'b0, i_cmd.n_ev};
    assign idx   = r_pos - i_cmd.unk;

    // Event at the current position of the head group
    always_comb begin
        if (r_pos < i_cmd.unk) begin
            ev_kind = KIND_END;
            ev_pay  = 8'h00;
        end else begin
            ev_kind = i_cmd.kind[idx[1:0]];
            ev_pay  = i_cmd.pay[idx[1:0]];
        end
        ev_last = (r_pos == total - 3'd1);
    end

    assign o_pop = load && !i_empty && ev_last;

    // Position within the head group
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= 3'd0;
        end else if (load && !i_empty) begin
            r_pos <= ev_last ? 3'd0 : r_pos + 3'd1;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= !i_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && !i_empty) begin
            r_kind <= ev_kind;
            r_pay  <= ev_pay;
            r_last <= ev_last;
        end
    end

    assign o_valid = r_valid;
    assign o_kind  = r_kind;
    assign o_pay   = r_pay;
    assign o_last  = r_last;

endmodule

/* sv/json_byte_tokenizer.sv */
// Top level of the streaming JSON byte tokenizer.
// Takes one text byte per cycle on the slave stream and lexes it in the same
// cycle; each byte yields up to five events (unknowns for a broken literal,
// a closing token, and the relexed byte's own event). Events leave on the
// master stream one per cycle while m_axis_tready is high, from a registered
// output, so a byte with several events holds the output until all have
// left; a four-entry queue of event groups between the lexer and the output
// absorbs such bursts, and the input stalls only while that queue is full.
// end_of_text arrives as tlast and resets the lexer after its closing events.
module json_byte_tokenizer import jbt_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] text_byte
    input  logic       s_axis_tlast,   // end_of_text
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] payload
    output logic [3:0] m_axis_tuser,   // [3:0] event_kind
    output logic       m_axis_tlast    // last_of_run
);

    logic q_push;
    logic q_pop;
    logic q_empty;
    logic q_full;
    t_cmd f_cmd;
    t_cmd q_cmd;

    // Lexer
    jbt_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_byte  (s_axis_tdata),
        .i_end   (s_axis_tlast),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_cmd   (f_cmd)
    );

    // Event group queue
    jbt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (f_cmd),
        .i_pop   (q_pop),
        .o_cmd   (q_cmd),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // Event serializer
    jbt_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .i_cmd   (q_cmd),
        .o_pop   (q_pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_kind  (m_axis_tuser),
        .o_pay   (m_axis_tdata),
        .o_last  (m_axis_tlast)
    );

endmodule
